[sv/assert_macros.svh]
// assertion helpers used by the checker in pehd_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/pehd_pkg.sv]
`timescale 1ns / 1ps
package pehd_pkg;

    localparam int PIN_W        = 5;
    localparam int TIME_W       = 32;
    localparam int HOLD_W       = 16;
    localparam int CH_OUT_W     = 3;
    localparam int CHANNELS_DEF = 5;

    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd90;

endpackage

[sv/pehd_if.sv]
`timescale 1ns / 1ps
// sample channel: pin levels and millisecond time
interface pehd_in_if;
    import pehd_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output pin_levels, output now_ms, input ready);
    modport sink (input valid, input pin_levels, input now_ms, output ready);
endinterface

// event channel
interface pehd_ev_if;
    import pehd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_OUT_W-1:0] channel;
    logic [TIME_W-1:0]   edge_time_ms;
    logic                last_event;

    modport source (output valid, output channel, output edge_time_ms, output last_event,
                    input ready);
    modport sink (input valid, input channel, input edge_time_ms, input last_event,
                  output ready);
endinterface

// holdoff register write channel
interface pehd_cfg_if;
    import pehd_pkg::*;

    logic              valid;
    logic              ready;
    logic [HOLD_W-1:0] holdoff_ms;

    modport source (output valid, output holdoff_ms, input ready);
    modport sink (input valid, input holdoff_ms, output ready);
endinterface

[sv/pehd_cmp.sv]
`timescale 1ns / 1ps
// shared elapsed-time unit: (now - last) mod 2^32 > holdoff
module pehd_cmp (
    input  logic [pehd_pkg::TIME_W-1:0] now_ms,
    input  logic [pehd_pkg::TIME_W-1:0] last_ms,
    input  logic [pehd_pkg::HOLD_W-1:0] holdoff_ms,
    output logic                        past_holdoff
);
    import pehd_pkg::*;

    logic [TIME_W-1:0] elapsed;

    assign elapsed      = now_ms - last_ms;
    assign past_holdoff = elapsed > {{(TIME_W-HOLD_W){1'b0}}, holdoff_ms};

endmodule

[sv/pehd_seq.sv]
`timescale 1ns / 1ps
// channel scan sequencer with per-channel state and output register
module pehd_seq #(
    parameter int CHANNELS = pehd_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pehd_pkg::PIN_W-1:0]    in_pins,
    input  logic [pehd_pkg::TIME_W-1:0]   in_now,
    input  logic [pehd_pkg::HOLD_W-1:0]   holdoff,
    output logic                          ev_valid,
    input  logic                          ev_ready,
    output logic [pehd_pkg::CH_OUT_W-1:0] ev_channel,
    output logic [pehd_pkg::TIME_W-1:0]   ev_time,
    output logic                          ev_last
);
    import pehd_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHANNELS-1:0] prev_reg, prev_next;
    logic [TIME_W-1:0]   last_reg [CHANNELS];
    logic [TIME_W-1:0]   last_next [CHANNELS];

    logic [CHANNELS-1:0] levels_reg, levels_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CH_OUT_W-1:0] pend_ch_reg, pend_ch_next;
    logic [CH_OUT_W-1:0] out_ch_reg, out_ch_next;
    logic [TIME_W-1:0]   out_time_reg, out_time_next;
    logic                out_last_reg, out_last_next;

    logic [CHANNELS-1:0] pins_ext;
    logic                lvl;
    logic                falling;
    logic                past_holdoff;
    logic                qual;
    logic                out_free;
    logic                out_load;

    // channels beyond the pin field read low
    for (genvar i = 0; i < CHANNELS; i++) begin : g_ext
        if (i < PIN_W) begin : g_pin
            assign pins_ext[i] = in_pins[i];
        end
        else begin : g_low
            assign pins_ext[i] = 1'b0;
        end
    end

    pehd_cmp u_cmp (
        .now_ms       (now_reg),
        .last_ms      (last_reg[idx_reg]),
        .holdoff_ms   (holdoff),
        .past_holdoff (past_holdoff)
    );

    assign lvl      = levels_reg[idx_reg];
    assign falling  = prev_reg[idx_reg] & ~lvl;
    assign qual     = falling & past_holdoff;
    assign out_free = !out_valid_reg || ev_ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        prev_next       = prev_reg;
        last_next       = last_reg;
        levels_next     = levels_reg;
        now_next        = now_reg;
        pend_ch_next    = pend_ch_reg;
        out_load        = 1'b0;
        out_ch_next     = out_ch_reg;
        out_time_next   = out_time_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    levels_next = pins_ext;
                    now_next    = in_now;
                    idx_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // hold the scan when a new event finds the held one unable to leave
                if (!(qual && pend_valid_reg && !out_free))
                begin
                    prev_next[idx_reg] = lvl;
                    if (falling)
                    begin
                        last_next[idx_reg] = now_reg;
                    end
                    if (qual)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load      = 1'b1;
                            out_ch_next   = pend_ch_reg;
                            out_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_ch_next    = CH_OUT_W'(idx_reg);
                    end
                    if (idx_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + CH_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_ch_next     = pend_ch_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_time_next  = now_reg;
            out_valid_next = 1'b1;
        end
        else if (ev_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_reg       <= prev_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        levels_reg   <= levels_next;
        now_reg      <= now_next;
        pend_ch_reg  <= pend_ch_next;
        out_ch_reg   <= out_ch_next;
        out_time_reg <= out_time_next;
        out_last_reg <= out_last_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign ev_valid   = out_valid_reg;
    assign ev_channel = out_ch_reg;
    assign ev_time    = out_time_reg;
    assign ev_last    = out_last_reg;

endmodule

[sv/pulse_edge_timestamp_holdoff_top.sv]
`timescale 1ns / 1ps
// flow: a sample is accepted in idle, then its channels are scanned one per cycle through the
//   shared elapsed-time compare unit while the event sink does not stall, then a flush state follows
// a new sample is accepted only after the flush state returns the sequencer to idle
// the first event of a sample is held pending and reaches the output when a later one qualifies or at flush
// reset: async active low, clears previous levels, edge times and holdoff (to 90) at once
module pulse_edge_timestamp_holdoff_top #(
    parameter int CHANNELS = pehd_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pehd_in_if.sink     in_ch,
    pehd_ev_if.source   ev_ch,
    pehd_cfg_if.sink    cfg_ch
);
    import pehd_pkg::*;

    // holdoff register, always writable
    logic [HOLD_W-1:0] holdoff_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg <= HOLDOFF_RESET;
        end
        else if (cfg_ch.valid)
        begin
            holdoff_reg <= cfg_ch.holdoff_ms;
        end
    end

    // sequencer walks the channels in ascending order, one per cycle unless the event output stalls; the most
    // recent qualified event is held back so the final one can carry the last mark
    pehd_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_pins    (in_ch.pin_levels),
        .in_now     (in_ch.now_ms),
        .holdoff    (holdoff_reg),
        .ev_valid   (ev_ch.valid),
        .ev_ready   (ev_ch.ready),
        .ev_channel (ev_ch.channel),
        .ev_time    (ev_ch.edge_time_ms),
        .ev_last    (ev_ch.last_event)
    );

endmodule

[sv/pehd_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// port-level checks of the edge detector
module pehd_chk #(
    parameter int CHANNELS = pehd_pkg::CHANNELS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          ev_valid,
    input logic                          ev_ready,
    input logic [pehd_pkg::CH_OUT_W-1:0] ev_channel,
    input logic [pehd_pkg::TIME_W-1:0]   ev_time,
    input logic                          ev_last
);
    import pehd_pkg::*;

    // a sample keeps the block busy for the following cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a held event that is not the last of its sample keeps the input closed
    `ASSERT_IMPL(a_busy_until_last, clk, rst_n, ev_valid && !ev_last, !in_ready)

    // reported channel lies within the scanned range
    `ASSERT_IMPL(a_channel_range, clk, rst_n, ev_valid, ev_channel < CHANNELS)

    // stalled event beat holds
    `ASSERT_NEXT(a_ev_hold, clk, rst_n, ev_valid && !ev_ready,
                 ev_valid && $stable(ev_channel) && $stable(ev_time) && $stable(ev_last))

endmodule

bind pulse_edge_timestamp_holdoff_top pehd_chk #(
    .CHANNELS (CHANNELS)
) u_pehd_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .ev_valid   (ev_ch.valid),
    .ev_ready   (ev_ch.ready),
    .ev_channel (ev_ch.channel),
    .ev_time    (ev_ch.edge_time_ms),
    .ev_last    (ev_ch.last_event)
);
